// ===== design/iods_pkg.sv =====
// Package for the I/O request dispatch scheduler: item types, codes and constants.
`timescale 1ns / 1ps
package iods_pkg;

	// Queue sizing default and discard starvation limit
	localparam int unsigned QueueDepthDefault = 16;
	localparam logic [7:0] DISCARD_LIMIT = 8'd128;

	// Number of queues and their codes (also the dispatch source codes)
	localparam int unsigned NUM_Q = 5;
	localparam logic [2:0] Q_DEQUE   = 3'd0;
	localparam logic [2:0] Q_META    = 3'd1;
	localparam logic [2:0] Q_DISCARD = 3'd2;
	localparam logic [2:0] Q_READ    = 3'd3;
	localparam logic [2:0] Q_WRITE   = 3'd4;

	// Request types
	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_DISPATCH = 2'd1;
	localparam logic [1:0] REQ_COMPLETE = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	// Result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOTHING = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_READ_EXPIRE   = 3'd0;
	localparam logic [2:0] CFG_WRITE_EXPIRE  = 3'd1;
	localparam logic [2:0] CFG_BATCH_LIMIT   = 3'd2;
	localparam logic [2:0] CFG_WSTARVE_LIMIT = 3'd3;
	localparam logic [2:0] CFG_TARGET_LAT    = 3'd4;

	// Configuration and batch threshold reset values
	localparam logic [15:0] READ_EXPIRE_RST   = 16'd200;
	localparam logic [15:0] WRITE_EXPIRE_RST  = 16'd25;
	localparam logic [7:0]  BATCH_LIMIT_RST   = 8'd16;
	localparam logic [7:0]  WSTARVE_LIMIT_RST = 8'd2;
	localparam logic [31:0] TARGET_LAT_RST    = 32'd8000000;
	localparam logic [7:0]  THRESHOLD_RST     = 8'd16;

	// One request item
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ticks;
		logic [15:0] tag;
		logic        is_write;
		logic        is_meta;
		logic        is_discard;
		logic        at_head;
		logic        is_passthrough;
		logic [31:0] latency_ns;
		logic        latency_valid;
	} req_item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_tag;
		logic [2:0]  out_source;
		logic        work_pending;
		logic [7:0]  batch_threshold;
	} rsp_item_t;

	// Wraparound time compare: a is after b
	function automatic logic wrap_after(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d != 32'd0) && !d[31];
	endfunction

endpackage

// ===== design/io_request_dispatch_scheduler_core.sv =====
// Top level of the I/O request dispatch scheduler: five queues, dispatch policy, latency average.
`timescale 1ns / 1ps
// A request item is registered on acceptance; once the output register can take it, the
// insert, dispatch or completion is decided from the queue heads and small counters
// and its result is written into the output register, so one item can be accepted every
// cycle while the result side takes items. Each of the five queues holds QUEUE_DEPTH tags
// (read and write queues also a deadline); an insert into a full queue returns status full.
// Configuration is written through the cfg port, which is always ready.
module io_request_dispatch_scheduler_core
	import iods_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_item_t   req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_item_t   rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

	// Configuration registers
	logic [15:0] read_expire_q, write_expire_q;
	logic [7:0]  batch_limit_q, wstarve_limit_q;
	logic [31:0] target_lat_q;

	// Scheduler state
	logic [PW-1:0] head_q [NUM_Q];
	logic [CW-1:0] count_q [NUM_Q];
	logic [15:0]   tag_mem [NUM_Q][QUEUE_DEPTH];
	logic [31:0]   dl_mem [2][QUEUE_DEPTH];
	logic [7:0]    batch_q, wstarved_q, dwait_q, thr_q;
	logic [31:0]   avg_q;

	// Input stage and output register
	req_item_t     item_s1;
	logic          valid_s1;
	logic          advance, fire;

	assign cfg_ready = 1'b1;
	assign advance = !rsp_valid || !rsp_stall;
	assign fire = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	// Next-state values
	logic [PW-1:0] head_n [NUM_Q];
	logic [CW-1:0] count_n [NUM_Q];
	logic [7:0]    batch_n, wstarved_n, dwait_n, thr_n;
	logic [31:0]   avg_n;
	logic          wr_en;
	logic [2:0]    wr_q;
	logic [PW-1:0] wr_idx;
	logic [31:0]   wr_dl;
	rsp_item_t     rsp_n;

	// Head reads
	logic [15:0] head_tag [NUM_Q];
	logic [31:0] rd_dl, wr_head_dl;
	logic [NUM_Q-1:0] nz;

	always_comb begin
		for (int i = 0; i < NUM_Q; i++) begin
			head_tag[i] = tag_mem[i][head_q[i]];
			nz[i] = count_q[i] != '0;
		end
		rd_dl = dl_mem[0][head_q[Q_READ]];
		wr_head_dl = dl_mem[1][head_q[Q_WRITE]];
	end

	// Decide the step for the registered item
	logic [2:0]      ins_q, src;
	logic            src_ok, done, wexp, rexp, bump_batch, pend;
	logic [SW-1:0]   tail_sum;
	logic [34:0]     avg_sum;
	logic [31:0]     avg_new;

	always_comb begin
		for (int i = 0; i < NUM_Q; i++) begin
			head_n[i] = head_q[i];
			count_n[i] = count_q[i];
		end
		batch_n = batch_q;
		wstarved_n = wstarved_q;
		dwait_n = dwait_q;
		thr_n = thr_q;
		avg_n = avg_q;
		wr_en = 1'b0;
		wr_q = Q_DEQUE;
		wr_idx = '0;
		wr_dl = '0;
		ins_q = Q_READ;
		src = Q_DEQUE;
		src_ok = 1'b0;
		done = 1'b0;
		wexp = 1'b0;
		rexp = 1'b0;
		bump_batch = 1'b0;
		tail_sum = '0;
		avg_sum = '0;
		avg_new = '0;
		rsp_n = '0;
		rsp_n.status = ST_DONE;

		case (item_s1.req_type)
			REQ_INSERT: begin
				// Route the tag
				if (item_s1.is_meta) ins_q = Q_META;
				else if (item_s1.is_discard) ins_q = Q_DISCARD;
				else if (item_s1.at_head || item_s1.is_passthrough) ins_q = Q_DEQUE;
				else if (item_s1.is_write) ins_q = Q_WRITE;
				else ins_q = Q_READ;
				if (count_q[ins_q] == FULL_CNT) begin
					rsp_n.status = ST_FULL;
				end else begin
					wr_en = 1'b1;
					wr_q = ins_q;
					count_n[ins_q] = count_q[ins_q] + 1'b1;
					if (ins_q == Q_DEQUE && !item_s1.is_meta && !item_s1.is_discard
							&& item_s1.at_head) begin
						wr_idx = (head_q[ins_q] == '0) ? LAST_PTR : head_q[ins_q] - 1'b1;
						head_n[ins_q] = wr_idx;
					end else begin
						tail_sum = SW'(head_q[ins_q]) + SW'(count_q[ins_q]);
						if (tail_sum >= SW'(QUEUE_DEPTH)) tail_sum = tail_sum - SW'(QUEUE_DEPTH);
						wr_idx = tail_sum[PW-1:0];
					end
					wr_dl = item_s1.now_ticks + ((ins_q == Q_WRITE) ?
						{16'd0, write_expire_q} : {16'd0, read_expire_q});
				end
			end
			REQ_DISPATCH: begin
				if (nz[Q_DEQUE]) begin
					src = Q_DEQUE; src_ok = 1'b1; done = 1'b1;
				end else if (nz[Q_META]) begin
					src = Q_META; src_ok = 1'b1; done = 1'b1;
				end else if (nz[Q_DISCARD]) begin
					// Age the waiting discards
					if (dwait_q != 8'hFF) dwait_n = dwait_q + 1'b1;
					if (dwait_q >= DISCARD_LIMIT) begin
						dwait_n = '0; src = Q_DISCARD; src_ok = 1'b1; done = 1'b1;
					end
				end
				if (!done && batch_q > thr_q) begin
					// Serve the most overdue expired FIFO head
					batch_n = '0;
					wexp = nz[Q_WRITE] && wrap_after(item_s1.now_ticks, wr_head_dl);
					rexp = nz[Q_READ] && wrap_after(item_s1.now_ticks, rd_dl);
					if (wexp && rexp) begin
						src = wrap_after(rd_dl, wr_head_dl) ? Q_WRITE : Q_READ;
						src_ok = 1'b1;
					end else if (wexp) begin
						src = Q_WRITE; src_ok = 1'b1;
					end else if (rexp) begin
						src = Q_READ; src_ok = 1'b1;
					end
					bump_batch = src_ok;
				end
				if (!done && !src_ok) begin
					if (nz[Q_READ]) begin
						src = Q_READ; src_ok = 1'b1; bump_batch = 1'b1;
						if (nz[Q_WRITE]) begin
							if (wstarved_q != 8'hFF) wstarved_n = wstarved_q + 1'b1;
							if (wstarved_q >= wstarve_limit_q) begin
								wstarved_n = '0; src = Q_WRITE;
							end
						end
					end else if (nz[Q_WRITE]) begin
						wstarved_n = '0; src = Q_WRITE; src_ok = 1'b1; bump_batch = 1'b1;
					end else if (nz[Q_DISCARD]) begin
						dwait_n = '0; src = Q_DISCARD; src_ok = 1'b1;
					end
				end
				if (bump_batch && batch_n != 8'hFF) batch_n = batch_n + 1'b1;
				// Pop the chosen head
				if (src_ok) begin
					rsp_n.out_tag = head_tag[src];
					rsp_n.out_source = src;
					head_n[src] = (head_q[src] == LAST_PTR) ? '0 : head_q[src] + 1'b1;
					count_n[src] = count_q[src] - 1'b1;
				end else begin
					rsp_n.status = ST_NOTHING;
				end
			end
			REQ_COMPLETE: begin
				// Fold the sample into the 1/8-weight average and step the threshold
				if (item_s1.latency_valid) begin
					avg_sum = ({avg_q, 3'b000} - {3'b000, avg_q}) + {3'b000, item_s1.latency_ns};
					avg_new = (avg_q == '0) ? item_s1.latency_ns : avg_sum[34:3];
					avg_n = avg_new;
					if (avg_new > target_lat_q) begin
						if (thr_q > 8'd1) thr_n = thr_q - 1'b1;
					end else if (thr_q < batch_limit_q) begin
						thr_n = thr_q + 1'b1;
					end
				end
			end
			default: ;
		endcase

		pend = 1'b0;
		for (int i = 0; i < NUM_Q; i++) pend = pend | (count_n[i] != '0);
		rsp_n.work_pending = pend;
		rsp_n.batch_threshold = thr_n;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_expire_q <= READ_EXPIRE_RST;
			write_expire_q <= WRITE_EXPIRE_RST;
			batch_limit_q <= BATCH_LIMIT_RST;
			wstarve_limit_q <= WSTARVE_LIMIT_RST;
			target_lat_q <= TARGET_LAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_READ_EXPIRE:   read_expire_q <= cfg_data[15:0];
				CFG_WRITE_EXPIRE:  write_expire_q <= cfg_data[15:0];
				CFG_BATCH_LIMIT:   batch_limit_q <= cfg_data[7:0];
				CFG_WSTARVE_LIMIT: wstarve_limit_q <= cfg_data[7:0];
				CFG_TARGET_LAT:    target_lat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state, input stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_Q; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
			end
			batch_q <= '0;
			wstarved_q <= '0;
			dwait_q <= '0;
			thr_q <= THRESHOLD_RST;
			avg_q <= '0;
			valid_s1 <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (fire) begin
				for (int i = 0; i < NUM_Q; i++) begin
					head_q[i] <= head_n[i];
					count_q[i] <= count_n[i];
				end
				batch_q <= batch_n;
				wstarved_q <= wstarved_n;
				dwait_q <= dwait_n;
				thr_q <= thr_n;
				avg_q <= avg_n;
			end
			if (advance) rsp_valid <= valid_s1;
			if (!req_stall) valid_s1 <= req_valid;
		end
	end

	// Payload registers and queue stores
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) item_s1 <= req;
		if (fire) rsp <= rsp_n;
		if (fire && wr_en) begin
			tag_mem[wr_q][wr_idx] <= item_s1.tag;
			if (wr_q == Q_READ) dl_mem[0][wr_idx] <= wr_dl;
			if (wr_q == Q_WRITE) dl_mem[1][wr_idx] <= wr_dl;
		end
	end

	// An empty dispatch leaves every queue empty
	a_nothing_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_NOTHING |-> !rsp.work_pending)
		else $error("empty dispatch with work pending");

	// The threshold never reaches zero
	a_thr_nonzero: assert property (@(posedge clk) disable iff (!arst_n) thr_q != 8'd0)
		else $error("batch threshold reached zero");

	// Input stalls only behind a held item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid && rsp_stall)
		else $error("input stalled without a held item");

	// A held result stays put while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule
